// ===== rtl/gls_pkg.sv =====
// Shared types and constants for the grid line-of-sight unit.
// No dependencies.
`timescale 1ns / 1ps

package gls_pkg;

   localparam int MAP_SIDE_DEF     = 64;
   localparam int CORNER_PREC_DEF  = 256;
   localparam int SLOPE_FRAC_DEF   = 16;

   localparam int CELL_W   = 6;
   localparam int RADIUS_W = 7;

   localparam logic [1:0] REG_VIEWER_X = 2'd0;
   localparam logic [1:0] REG_VIEWER_Y = 2'd1;
   localparam logic [1:0] REG_RADIUS   = 2'd2;

   localparam logic MODE_WRITE = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_RANGE,
      ST_SETUP,
      ST_DIVGO,
      ST_DIV,
      ST_STEP,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

// ===== rtl/gls_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module gls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/gls_div.sv =====
// Restoring divider for the ray slope: quot = (num << FB) / den, num <= den.
// Depends on gls_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module gls_div
   import gls_pkg::*;
#(
   parameter int DW = 15,
   parameter int FB = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] num,
   input  logic [DW-1:0] den,
   output div_ctl_type   ctl,
   output logic [FB:0]   quot
);

   localparam int CNTW = $clog2(FB + 2);

   logic [DW:0]     rem_ff, rem_in;
   logic [DW-1:0]   den_ff;
   logic [FB:0]     q_ff, q_in;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff;
   logic            ge;
   logic [DW:0]     diff;

   assign ge     = rem_ff >= {1'b0, den_ff};
   assign diff   = ge ? rem_ff - {1'b0, den_ff} : rem_ff;
   assign rem_in = {diff[DW-1:0], 1'b0};
   assign q_in   = {q_ff[FB-1:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= CNTW'(FB);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign ctl.start = start;
   assign ctl.done  = done_ff;
   assign quot      = q_ff;

endmodule

// ===== rtl/grid_line_of_sight_unit.sv =====
// Top level of the grid line-of-sight unit: wall map RAM, ray sequencer, CSRs.
// Depends on gls_pkg, gls_ram and gls_div.
`timescale 1ns / 1ps

// Keeps a wall bit per map cell in one RAM and answers visibility queries
// from the viewer cell set in the CSRs. After reset the map is swept clear,
// one cell per cycle, over all (2**clog2(MAP_SIDE))**2 cells (4096 at the default
// side); requests are held off during the sweep, CSR writes still land.
// A write request passes through ST_WRITE, then ST_DONE, which registers its
// response; an out-of-range query does the same through ST_RANGE. An in-range
// query adds, for each of up to four corner rays, a setup step (ST_SETUP,
// ST_DIVGO), the serial slope divider, and per sample a map RAM read
// (ST_STEP), then the wall test (ST_CHECK), with about radius
// samples per ray. Queries stop at the first clear ray. One request is
// worked at a time; the next one can be taken while a response waits.
module grid_line_of_sight_unit
   import gls_pkg::*;
#(
   parameter int MAP_SIDE         = MAP_SIDE_DEF,
   parameter int CORNER_PRECISION = CORNER_PREC_DEF,
   parameter int SLOPE_FRAC_BITS  = SLOPE_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cell_x[5:0], cell_y[11:6], wall_bit[12], zero pad
   input  logic        req_tuser,   // mode[0]: 0 write, 1 query
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // visible[0], in_range[1], zero pad
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MW    = $clog2(MAP_SIDE);
   localparam int RAW   = 2 * MW;
   localparam int DEPTH = 1 << RAW;
   localparam int CP2   = 2 * CORNER_PRECISION;
   localparam int CW    = $clog2(CP2 * (1 << CELL_W)) + 1;  // signed coordinate
   localparam int DW    = CW - 1;                           // magnitude
   localparam int FB    = SLOPE_FRAC_BITS;
   localparam int IW    = CELL_W + 4;                       // signed cell index
   localparam int ACW   = FB + IW;                          // minor accumulator

   // ---------------- CSRs ----------------
   logic [CELL_W-1:0]   viewer_x_ff, viewer_y_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         viewer_x_ff <= '0;
         viewer_y_ff <= '0;
         radius_ff   <= RADIUS_W'(8);
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_VIEWER_X: viewer_x_ff <= csr_pwdata[CELL_W-1:0];
            REG_VIEWER_Y: viewer_y_ff <= csr_pwdata[CELL_W-1:0];
            REG_RADIUS:   radius_ff   <= csr_pwdata[RADIUS_W-1:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_VIEWER_X: csr_prdata = 32'(viewer_x_ff);
         REG_VIEWER_Y: csr_prdata = 32'(viewer_y_ff);
         REG_RADIUS:   csr_prdata = 32'(radius_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- helpers ----------------
   function automatic logic in_map(input logic signed [IW-1:0] v);
      return !v[IW-1] && (v < $signed(IW'(MAP_SIDE)));
   endfunction

   // ---------------- request capture ----------------
   state_type state_ff, state_in;

   logic              mode_ff, wall_ff;
   logic [CELL_W-1:0] cx_ff, cy_ff;
   logic              req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // ---------------- range test ----------------
   logic signed [CELL_W:0]     ex, ey;
   logic [CELL_W:0]            nex, ney;
   logic [CELL_W-1:0]          aex, aey;
   logic [2*CELL_W+2:0]        dist2;
   logic [2*RADIUS_W-1:0]      r2;
   logic                       range_now;

   assign ex        = $signed({1'b0, cx_ff}) - $signed({1'b0, viewer_x_ff});
   assign ey        = $signed({1'b0, cy_ff}) - $signed({1'b0, viewer_y_ff});
   assign nex       = (CELL_W+1)'(-ex);
   assign ney       = (CELL_W+1)'(-ey);
   assign aex       = ex[CELL_W] ? nex[CELL_W-1:0] : ex[CELL_W-1:0];
   assign aey       = ey[CELL_W] ? ney[CELL_W-1:0] : ey[CELL_W-1:0];
   assign dist2     = (2*CELL_W+3)'(aex) * (2*CELL_W+3)'(aex)
                    + (2*CELL_W+3)'(aey) * (2*CELL_W+3)'(aey);
   assign r2        = (2*RADIUS_W)'(radius_ff) * (2*RADIUS_W)'(radius_ff);
   assign range_now = (2*RADIUS_W+1)'(dist2) < (2*RADIUS_W+1)'(r2);

   // ---------------- ray setup ----------------
   logic [1:0]          ray_ff;
   logic [CW-1:0]       tx, ty, vcx, vcy;
   logic signed [CW-1:0] dx, dy;
   logic [CW-1:0]       ndx, ndy;
   logic [DW-1:0]       adx, ady;
   logic                steep;
   logic [DW-1:0]       amaj_ff, amin_ff;
   logic                steep_ff, flip_ff, sneg_ff, maj_zero;
   logic [CELL_W-1:0]   vmaj_ff, vmin_ff;

   assign tx  = CW'(cx_ff) * CW'(CP2) + (ray_ff[1] ? CW'(CP2 - 2) : CW'(2));
   assign ty  = CW'(cy_ff) * CW'(CP2) + (ray_ff[0] ? CW'(CP2 - 2) : CW'(2));
   assign vcx = CW'({viewer_x_ff, 1'b1}) * CW'(CORNER_PRECISION);
   assign vcy = CW'({viewer_y_ff, 1'b1}) * CW'(CORNER_PRECISION);
   assign dx  = $signed(tx - vcx);
   assign dy  = $signed(ty - vcy);
   assign ndx = CW'(-dx);
   assign ndy = CW'(-dy);
   assign adx = dx[CW-1] ? ndx[DW-1:0] : dx[DW-1:0];
   assign ady = dy[CW-1] ? ndy[DW-1:0] : dy[DW-1:0];
   assign steep = adx < ady;
   assign maj_zero = steep ? (dy == '0) : (dx == '0);

   // ---------------- slope divider ----------------
   div_ctl_type div_ctl;
   logic [FB:0] quot;
   logic        div_start;

   gls_div #(.DW(DW), .FB(FB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (amin_ff),
      .den   (amaj_ff),
      .ctl   (div_ctl),
      .quot  (quot)
   );

   // ---------------- stepping ----------------
   logic signed [ACW-1:0] acc_ff, inc_ff, start_val;
   logic signed [IW-1:0]  jc_ff, mc, mx, my;
   logic [CW-1:0]         pos_ff, pos_next;
   logic                  inmap_ff, inmap_now;
   logic [RAW-1:0]        rd_addr;
   logic                  rd_wall, wall_hit, ray_done;

   assign start_val = $signed(ACW'({vmin_ff, 1'b1}) << (FB - 1));
   assign mc        = acc_ff[ACW-1:FB];
   assign mx        = steep_ff ? mc : jc_ff;
   assign my        = steep_ff ? jc_ff : mc;
   assign inmap_now = in_map(mx) && in_map(my);
   assign rd_addr   = {my[MW-1:0], mx[MW-1:0]};
   assign wall_hit  = inmap_ff && rd_wall;
   assign pos_next  = pos_ff + CW'(CP2);
   assign ray_done  = pos_next >= CW'(amaj_ff);

   // ---------------- map RAM and clear sweep ----------------
   logic [RAW-1:0]        clr_ff;
   logic                  ram_we, ram_wd;
   logic [RAW-1:0]        ram_wa;
   logic signed [IW-1:0]  wx, wy;

   assign wx = $signed(IW'(cx_ff));
   assign wy = $signed(IW'(cy_ff));

   gls_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .raddr (rd_addr),
      .rdata (rd_wall)
   );

   // ---------------- response ----------------
   logic rsp_valid_ff, vis_ff, rng_ff;
   logic vis_res_ff;
   logic rng_keep_ff;   // range flag held for the response
   logic rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rng_ff, vis_ff};

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_acc) state_in = (req_tuser == MODE_WRITE) ? ST_WRITE : ST_RANGE;
         end
         ST_WRITE: state_in = ST_DONE;
         ST_RANGE: state_in = range_now ? ST_SETUP : ST_DONE;
         ST_SETUP: state_in = maj_zero ? ST_DONE : ST_DIVGO;
         ST_DIVGO: state_in = ST_DIV;
         ST_DIV:   if (div_ctl.done) state_in = ST_STEP;
         ST_STEP:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (wall_hit) state_in = (ray_ff == 2'd3) ? ST_DONE : ST_SETUP;
            else          state_in = ray_done ? ST_DONE : ST_STEP;
         end
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      div_start = 1'b0;
      ram_we    = 1'b0;
      ram_wa    = clr_ff;
      ram_wd    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: ram_we = 1'b1;
         ST_WRITE: begin
            ram_we = in_map(wx) && in_map(wy);
            ram_wa = {wy[MW-1:0], wx[MW-1:0]};
            ram_wd = wall_ff;
         end
         ST_DIVGO: div_start = 1'b1;
         default:  ;
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                rsp_valid_ff <= 1'b0;
      end

      if (req_acc) begin
         mode_ff <= req_tuser;
         cx_ff   <= req_tdata[5:0];
         cy_ff   <= req_tdata[11:6];
         wall_ff <= req_tdata[12];
      end

      unique case (state_ff)
         ST_RANGE: begin
            ray_ff     <= 2'd0;
            vis_res_ff <= 1'b0;
         end
         ST_SETUP: begin
            steep_ff <= steep;
            amaj_ff  <= steep ? ady : adx;
            amin_ff  <= steep ? adx : ady;
            flip_ff  <= (dx[CW-1] != dy[CW-1]) ^ (steep ? dy[CW-1] : dx[CW-1]);
            sneg_ff  <= steep ? dy[CW-1] : dx[CW-1];
            vmaj_ff  <= steep ? viewer_y_ff : viewer_x_ff;
            vmin_ff  <= steep ? viewer_x_ff : viewer_y_ff;
            if (maj_zero) vis_res_ff <= 1'b1;
         end
         ST_DIV: begin
            acc_ff <= start_val;
            inc_ff <= flip_ff ? -$signed(ACW'(quot)) : $signed(ACW'(quot));
            jc_ff  <= $signed(IW'(vmaj_ff));
            pos_ff <= '0;
         end
         ST_STEP: inmap_ff <= inmap_now;
         ST_CHECK: begin
            if (wall_hit) begin
               ray_ff <= ray_ff + 1'b1;
            end else begin
               acc_ff <= acc_ff + inc_ff;
               jc_ff  <= sneg_ff ? jc_ff - IW'(1) : jc_ff + IW'(1);
               pos_ff <= pos_next;
               if (ray_done) vis_res_ff <= 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               vis_ff <= (mode_ff != MODE_WRITE) && vis_res_ff;
               rng_ff <= (mode_ff != MODE_WRITE) && rng_keep_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RANGE) rng_keep_ff <= range_now;
      else if (state_ff == ST_WRITE) rng_keep_ff <= 1'b0;
   end

endmodule

// ===== rtl/gls_checker.sv =====
// Port-level checker for the grid line-of-sight unit, bound to the top level.
// Depends on grid_line_of_sight_unit.
`timescale 1ns / 1ps

module gls_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // seen implies in range
   a_vis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[0] || rsp_tdata[1]))
      else $error("visible without in_range");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // reset empties the response slot and holds off requests
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind grid_line_of_sight_unit gls_checker u_gls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
